// ----- rtl/pse_pkg.sv -----
`default_nettype none
package pse_pkg;

  // run counter width, holds counts up to the largest run limit
  localparam int COUNT_W = 7;

  // graphic character bounds
  localparam logic [7:0] GRAPH_LO = 8'h21;
  localparam logic [7:0] GRAPH_HI = 8'h7E;

  // register map, index bit taken from paddr[2]
  localparam logic IDX_MIN_LENGTH = 1'b0;
  localparam logic [5:0] MIN_LENGTH_RESET = 6'd5;

  // controller to datapath commands
  typedef struct packed {
    logic load;         // latch input word
    logic close;        // clear run count and reporting flag
    logic emit_end;     // send end marker
    logic emit_char;    // send current byte, count it
    logic hold;         // store current byte in hold buffer, count it
    logic start_burst;  // mark run as reporting, rewind burst index
    logic fetch;        // read hold buffer at burst index
    logic emit_held;    // send fetched byte, advance burst index
    logic pos_inc;      // advance byte offset
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic graphic;
    logic cut;
    logic reporting;
    logic reach_min;
    logic burst_last;
    logic out_free;
    logic last;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/pse_ctrl.sv -----
`default_nettype none
module pse_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire pse_pkg::sts_t sts,
  output pse_pkg::cmd_t      cmd
);
  import pse_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CUT,
    S_CHAR,
    S_FETCH,
    S_BURST,
    S_LAST
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CUT;
        end
      end
      // full chunk: close it before the new character
      S_CUT: begin
        if (sts.graphic && sts.cut) begin
          if (!sts.reporting) begin
            cmd.close  = 1'b1;
            state_next = S_CHAR;
          end else if (sts.out_free) begin
            cmd.emit_end = 1'b1;
            cmd.close    = 1'b1;
            state_next   = S_CHAR;
          end
        end else begin
          state_next = S_CHAR;
        end
      end
      S_CHAR: begin
        if (sts.graphic) begin
          if (sts.reporting) begin
            if (sts.out_free) begin
              cmd.emit_char = 1'b1;
              state_next    = S_LAST;
            end
          end else begin
            cmd.hold = 1'b1;
            if (sts.reach_min) begin
              cmd.start_burst = 1'b1;
              state_next      = S_FETCH;
            end else begin
              state_next = S_LAST;
            end
          end
        end else if (!sts.reporting) begin
          cmd.close  = 1'b1;
          state_next = S_LAST;
        end else if (sts.out_free) begin
          cmd.emit_end = 1'b1;
          cmd.close    = 1'b1;
          state_next   = S_LAST;
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_BURST;
      end
      // send held characters once the minimum is met
      S_BURST: begin
        if (sts.out_free) begin
          cmd.emit_held = 1'b1;
          state_next    = sts.burst_last ? S_LAST : S_FETCH;
        end
      end
      // advance the byte offset; stream end also closes the open run
      S_LAST: begin
        if (!sts.last) begin
          cmd.pos_inc = 1'b1;
          state_next  = S_IDLE;
        end else if (!sts.reporting) begin
          cmd.close   = 1'b1;
          cmd.pos_inc = 1'b1;
          state_next  = S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit_end = 1'b1;
          cmd.close    = 1'b1;
          cmd.pos_inc  = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/pse_dp.sv -----
`default_nettype none
module pse_dp #(
  parameter int RUN_LIMIT  = 99,
  parameter int HOLD_DEPTH = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire pse_pkg::cmd_t cmd,
  output pse_pkg::sts_t      sts,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_last,
  input  wire logic          cfg_we,
  input  wire logic [5:0]    cfg_min,
  output logic [5:0]         min_length,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [39:0]        out_data,
  output logic               out_user,
  output logic               out_last
);
  import pse_pkg::*;

  localparam int AW = $clog2(HOLD_DEPTH);
  localparam logic [COUNT_W-1:0] RunLim = COUNT_W'(RUN_LIMIT);
  localparam logic [COUNT_W-1:0] HoldD  = COUNT_W'(HOLD_DEPTH);
  localparam int MinRstA = (MIN_LENGTH_RESET > HOLD_DEPTH) ? HOLD_DEPTH : MIN_LENGTH_RESET;
  localparam int MinRstB = (MinRstA > RUN_LIMIT) ? RUN_LIMIT : MinRstA;
  localparam logic [COUNT_W-1:0] MinRst = COUNT_W'(MinRstB);

  logic [7:0]         byte_q;
  logic               last_q;
  logic [COUNT_W-1:0] run_count;
  logic [31:0]        run_start;
  logic [31:0]        byte_position;
  logic               reporting;
  logic [COUNT_W-1:0] eff_min;
  logic [COUNT_W-1:0] eff_min_next;
  logic [AW-1:0]      burst_idx;
  logic [7:0]         rd_data;
  logic [7:0]         held [HOLD_DEPTH];

  // clamp a written minimum into the usable range
  always_comb begin
    eff_min_next = {1'b0, cfg_min};
    if (eff_min_next == '0) begin
      eff_min_next = COUNT_W'(1);
    end
    if (eff_min_next > HoldD) begin
      eff_min_next = HoldD;
    end
    if (eff_min_next > RunLim) begin
      eff_min_next = RunLim;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= MIN_LENGTH_RESET;
      eff_min    <= MinRst;
    end else if (cfg_we) begin
      min_length <= cfg_min;
      eff_min    <= eff_min_next;
    end
  end

  // input word latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_q <= in_byte;
      last_q <= in_last;
    end
  end

  // run state
  always_ff @(posedge clk) begin
    if (rst) begin
      run_count     <= '0;
      run_start     <= '0;
      byte_position <= '0;
      reporting     <= 1'b0;
      burst_idx     <= '0;
    end else begin
      if (cmd.close) begin
        run_count <= '0;
        reporting <= 1'b0;
      end else if (cmd.hold || cmd.emit_char) begin
        run_count <= run_count + COUNT_W'(1);
      end
      if (cmd.hold && run_count == '0) begin
        run_start <= byte_position;
      end
      if (cmd.start_burst) begin
        reporting <= 1'b1;
        burst_idx <= '0;
      end else if (cmd.emit_held) begin
        burst_idx <= burst_idx + AW'(1);
      end
      if (cmd.pos_inc) begin
        byte_position <= byte_position + 32'd1;
      end
    end
  end

  // hold buffer
  always_ff @(posedge clk) begin
    if (cmd.hold) begin
      held[run_count[AW-1:0]] <= byte_q;
    end
    if (cmd.fetch) begin
      rd_data <= held[burst_idx];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_end || cmd.emit_char || cmd.emit_held) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_end) begin
      out_data <= {8'h00, run_start};
      out_user <= 1'b0;
      out_last <= 1'b1;
    end else if (cmd.emit_char) begin
      out_data <= {byte_q, run_start};
      out_user <= 1'b1;
      out_last <= 1'b0;
    end else if (cmd.emit_held) begin
      out_data <= {rd_data, run_start};
      out_user <= 1'b1;
      out_last <= 1'b0;
    end
  end

  // status to controller
  assign sts.graphic    = (byte_q >= GRAPH_LO) && (byte_q <= GRAPH_HI);
  assign sts.cut        = (run_count >= RunLim);
  assign sts.reporting  = reporting;
  assign sts.reach_min  = ((run_count + COUNT_W'(1)) >= eff_min);
  assign sts.burst_last = ({{(COUNT_W - AW){1'b0}}, burst_idx} == (run_count - COUNT_W'(1)));
  assign sts.out_free   = !out_valid || out_ready;
  assign sts.last       = last_q;

endmodule
`default_nettype wire

// ----- rtl/printable_string_extractor.sv -----
`default_nettype none
// channel   dir  fields (low bit up)
// s_*       in   tdata: data_byte[7:0]; tlast: stream_end
// m_*       out  tdata: start_offset[31:0], char_out[39:32]; tuser: char_valid;
//                tlast: string_end
// apb       in   0x0: min_length[5:0]
//
// one byte at a time, in steps accept, chunk cut, char and close,
// plus a fetch and a send step per held character when the minimum is reached,
// since the hold buffer has one registered read port.
// a stalled output register holds the controller in its emit state.
// rst is synchronous, active high; no clearing pass is needed.
module printable_string_extractor #(
  parameter int RUN_LIMIT  = 99,
  parameter int HOLD_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // data_byte
  input  wire logic        s_tlast,   // stream_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // start_offset[31:0], char_out[39:32]
  output logic             m_tuser,   // char_valid
  output logic             m_tlast,   // string_end
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import pse_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  logic       cfg_we;
  logic [5:0] min_length;

  // register decode
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == IDX_MIN_LENGTH);
  assign prdata = (paddr[2] == IDX_MIN_LENGTH) ? {26'd0, min_length} : 32'd0;

  pse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pse_dp #(
    .RUN_LIMIT  (RUN_LIMIT),
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_byte    (s_tdata),
    .in_last    (s_tlast),
    .cfg_we     (cfg_we),
    .cfg_min    (pwdata[5:0]),
    .min_length (min_length),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata),
    .out_user   (m_tuser),
    .out_last   (m_tlast)
  );

endmodule
`default_nettype wire

// ----- rtl/pse_checker.sv -----
`default_nettype none
module pse_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic        m_tuser,
  input wire logic        m_tlast
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output word changed under stall");

  // end marker carries no character
  a_end_word: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !m_tuser && (m_tdata[39:32] == 8'h00))
    else $error("end marker with character");

  // character word is graphic and not an end marker
  a_char_word: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> !m_tlast && (m_tdata[39:32] >= 8'h21)
      && (m_tdata[39:32] <= 8'h7E))
    else $error("bad character word");

  // one byte in flight at a time
  a_one_byte: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("byte accepted while busy");

endmodule

bind printable_string_extractor pse_checker u_pse_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
`default_nettype wire

// ----- tb/tb.sv -----
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pse_pkg::*;

  localparam int RUN_LIMIT  = 99;
  localparam int HOLD_DEPTH = 32;
  // cycles to let pass once nothing is expected
  localparam int DRAIN      = 120;
  localparam int LONG_HOLD  = 400;

  // one result word as seen on the master side
  typedef struct packed {
    logic [31:0] start_offset;
    logic [7:0]  char_out;
    logic        char_valid;
    logic        string_end;
  } str_word_t;

  // run tracker and store of expected words
  class run_scoreboard;
    logic [7:0]  held [HOLD_DEPTH];
    logic [6:0]  run_count;
    logic [31:0] run_start;
    logic [31:0] byte_pos;
    logic        reporting;
    logic [5:0]  min_length;
    str_word_t   expected_q [$];
    int          errors;

    function new();
      run_count  = '0;
      run_start  = '0;
      byte_pos   = '0;
      reporting  = 1'b0;
      min_length = MIN_LENGTH_RESET;
      errors     = 0;
    endfunction

    // threshold as the block applies it
    function int eff_min();
      int m;
      m = min_length;
      if (m < 1) m = 1;
      if (m > HOLD_DEPTH) m = HOLD_DEPTH;
      if (m > RUN_LIMIT) m = RUN_LIMIT;
      return m;
    endfunction

    function void set_min(logic [5:0] v);
      min_length = v;
    endfunction

    function void push_word(logic [7:0] ch, logic valid, logic fin);
      str_word_t w;
      w.start_offset = run_start;
      w.char_out     = valid ? ch : 8'h00;
      w.char_valid   = valid;
      w.string_end   = fin;
      expected_q.push_back(w);
    endfunction

    function void close_run();
      if (reporting) push_word(8'h00, 1'b0, 1'b1);
      run_count = '0;
      reporting = 1'b0;
    endfunction

    // called for every accepted input word
    function void note_byte(logic [7:0] b, logic last);
      int i;
      if (b >= GRAPH_LO && b <= GRAPH_HI) begin
        // chunk full: close it, this char opens the next one
        if (run_count >= RUN_LIMIT) close_run();
        if (run_count == 0) run_start = byte_pos;
        if (reporting) begin
          push_word(b, 1'b1, 1'b0);
          run_count++;
        end else begin
          if (run_count < HOLD_DEPTH) held[run_count] = b;
          run_count++;
          // threshold reached: flush the held chars as a burst
          if (run_count >= eff_min()) begin
            for (i = 0; i < run_count && i < HOLD_DEPTH; i++)
              push_word(held[i], 1'b1, 1'b0);
            reporting = 1'b1;
          end
        end
      end else begin
        close_run();
      end
      if (last) close_run();
      byte_pos = byte_pos + 32'd1;
    endfunction

    // called for every accepted output word
    function void check_word(str_word_t got);
      str_word_t exp;
      if (expected_q.size() == 0) begin
        $error("unexpected word: start_offset %h char_out %h char_valid %b string_end %b",
               got.start_offset, got.char_out, got.char_valid, got.string_end);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.start_offset !== exp.start_offset) begin
        $error("start_offset: expected %h, actual %h", exp.start_offset, got.start_offset);
        errors++;
      end
      if (got.char_out !== exp.char_out) begin
        $error("char_out: expected %h, actual %h", exp.char_out, got.char_out);
        errors++;
      end
      if (got.char_valid !== exp.char_valid) begin
        $error("char_valid: expected %b, actual %b", exp.char_valid, got.char_valid);
        errors++;
      end
      if (got.string_end !== exp.string_end) begin
        $error("string_end: expected %b, actual %b", exp.string_end, got.string_end);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // data_byte
  logic        s_tlast = 1'b0;    // stream_end
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;           // start_offset[31:0], char_out[39:32]
  logic        m_tuser;           // char_valid
  logic        m_tlast;           // string_end
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  run_scoreboard sb;
  bit  hold_req = 1'b0;
  bit  no_gaps = 1'b0;
  int  burst_left = 0;
  int  items_sent = 0;

  printable_string_extractor dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watch both handshakes, results first since they never stem from this edge's input
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready)
        sb.check_word({m_tdata[31:0], m_tdata[39:32], m_tuser, m_tlast});
      if (s_tvalid && s_tready)
        sb.note_byte(s_tdata, s_tlast);
    end
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin : receiver
    int cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        case ((cyc / 97) % 4)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 1) == 1);
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ((cyc % 3) != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("printable_string_extractor regression: fail");
    $finish;
  end

  function automatic logic [7:0] graphic_byte();
    return 8'($urandom_range(GRAPH_LO, GRAPH_HI));
  endfunction

  // any byte outside 0x21..0x7e
  function automatic logic [7:0] other_byte();
    int r;
    r = $urandom_range(0, 161);
    return (r < 33) ? 8'(r) : 8'(r + 94);
  endfunction

  // offer one word, sender may idle between bursts
  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0 || no_gaps) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tdata  <= b;
    s_tlast  <= last;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // stop offering and wait until every expected word is out
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // write min_length and read it back
  task automatic write_min(logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {IDX_MIN_LENGTH, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_min(value[5:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {26'd0, value[5:0]}) begin
      $error("min_length readback: expected %h, actual %h", {26'd0, value[5:0]}, prdata);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // graphic run of random content followed by a random terminator
  task automatic send_run(int len);
    int term;
    int i;
    term = $urandom_range(0, 3);
    for (i = 0; i < len; i++)
      send_byte(graphic_byte(), (i == len - 1) && (term == 0));
    if (term == 1 || term == 3) send_byte(other_byte(), 1'b0);
    else if (term == 2) send_byte(other_byte(), 1'b1);
  endtask

  // mostly runs around the threshold, some noise
  task automatic random_phase(int n);
    int start;
    int m;
    int sel;
    start = items_sent;
    m = sb.eff_min();
    while (items_sent - start < n) begin
      sel = $urandom_range(0, 9);
      if (sel < 5) send_run($urandom_range((m > 2) ? m - 2 : 1, m + 2));
      else if (sel < 7) send_run($urandom_range(1, 8));
      else if (sel < 8) send_run($urandom_range(m, m + 40));
      else send_byte(($urandom_range(0, 1) == 1) ? other_byte() : graphic_byte(),
                     ($urandom_range(0, 7) == 0));
    end
  endtask

  initial begin : stimulus
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, default threshold of 5
    // run too short, ended by a space
    send_byte(8'h61, 1'b0); send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b0); send_byte(8'h64, 1'b0);
    send_byte(8'h20, 1'b0);
    // graphic bounds reach the threshold, one more char, then nul
    send_byte(GRAPH_LO, 1'b0); send_byte(GRAPH_HI, 1'b0);
    send_byte(8'h41, 1'b0); send_byte(8'h5a, 1'b0); send_byte(8'h7a, 1'b0);
    send_byte(8'h30, 1'b0);
    send_byte(8'h00, 1'b0);
    // stream end on the char that reaches the threshold
    send_byte(8'h41, 1'b0); send_byte(8'h42, 1'b0); send_byte(8'h43, 1'b0);
    send_byte(8'h44, 1'b0); send_byte(8'h45, 1'b1);
    // bytes outside the graphic range, stream end on a non-graphic
    send_byte(8'hff, 1'b1); send_byte(8'h7f, 1'b0); send_byte(8'h20, 1'b1);
    send_byte(8'h80, 1'b0);
    // short run closed by stream end
    send_byte(8'h7e, 1'b0); send_byte(8'h21, 1'b1);
    random_phase(30);
    wait_idle();

    // threshold of one
    write_min(32'd1);
    random_phase(30);
    wait_idle();

    // largest threshold, long run with chunk cuts while the receiver holds off
    write_min(32'd32);
    hold_req = 1'b1;
    send_run(130);
    random_phase(30);
    wait_idle();

    // zero acts as one
    write_min(32'd0);
    random_phase(30);
    wait_idle();

    // above the hold depth acts as the hold depth
    write_min(32'd63);
    random_phase(30);
    wait_idle();

    // random threshold, upper data bits noise, no sender idling
    write_min({26'($urandom_range(0, 32'h03ff_ffff)), 6'($urandom_range(2, 31))});
    no_gaps = 1'b1;
    random_phase(30);
    wait_idle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("printable_string_extractor regression: pass");
    end else begin
      $display("printable_string_extractor regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- printable_string_extractor.f -----
rtl/pse_pkg.sv
rtl/pse_ctrl.sv
rtl/pse_dp.sv
rtl/printable_string_extractor.sv
rtl/pse_checker.sv
tb/tb.sv
